>>> hdl/lca_pkg.sv
// Shared types and constants for the life cellular automaton block.
// No dependencies; used by lca_row_cell, life_cellular_automaton_top and the testbench files.
package lca_pkg;

	// default grid edge length
	localparam int GRID_SIZE_DEF = 32;

	// field widths
	localparam int KIND_W = 2;
	localparam int IDX_W  = 10;
	localparam int SEL_W  = 5;
	localparam int RB_W   = 32;
	// linear index width that covers the largest grid (64 x 64)
	localparam int LIN_W  = 13;

	// stream word widths
	localparam int S_DATA_W = 16;
	localparam int S_USER_W = KIND_W;
	localparam int M_DATA_W = RB_W;

	// operation codes carried in tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_MARK  = 2'd1,
		KIND_STEP  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	// control broadcast from the top level to every row cell
	typedef struct packed {
		logic             clear;
		logic             mark;
		logic             step;
		logic [IDX_W-1:0] cell_number;
	} ctrl_t;

endpackage

>>> hdl/lca_row_cell.sv
// One row of the grid: holds its live bits and updates them from its own
// row and the rows handed in by the cells above and below. Uses lca_pkg.
module lca_row_cell #(
	parameter int GRID_SIZE = lca_pkg::GRID_SIZE_DEF,
	parameter int ROW_IDX   = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lca_pkg::ctrl_t       ctrl,
	input  logic [GRID_SIZE-1:0] up_row,
	input  logic [GRID_SIZE-1:0] dn_row,
	output logic [GRID_SIZE-1:0] row
);

	localparam int COL_W = $clog2(GRID_SIZE);
	localparam logic [lca_pkg::LIN_W-1:0] BASE  = lca_pkg::LIN_W'(ROW_IDX * GRID_SIZE);
	localparam logic [lca_pkg::LIN_W-1:0] LIMIT =
		lca_pkg::LIN_W'((ROW_IDX + 1) * GRID_SIZE);

	logic [GRID_SIZE-1:0]     row_q;
	logic [GRID_SIZE-1:0]     gen_row;
	logic [GRID_SIZE+1:0]     up_pad, own_pad, dn_pad;
	logic [lca_pkg::LIN_W-1:0] num;
	logic [lca_pkg::LIN_W-1:0] offs;
	logic [COL_W-1:0]         col;
	logic                     hit;

	// zero padding stands for dead cells beyond the edges
	assign up_pad  = {1'b0, up_row, 1'b0};
	assign own_pad = {1'b0, row_q, 1'b0};
	assign dn_pad  = {1'b0, dn_row, 1'b0};

	// B3/S23 per column, one neighbour adder each
	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < GRID_SIZE; c++) begin
			n = 4'(up_pad[c]) + 4'(up_pad[c+1]) + 4'(up_pad[c+2])
			  + 4'(own_pad[c]) + 4'(own_pad[c+2])
			  + 4'(dn_pad[c]) + 4'(dn_pad[c+1]) + 4'(dn_pad[c+2]);
			gen_row[c] = (n == 4'd3) || (row_q[c] && (n == 4'd2));
		end
	end

	// does the marked index fall in this row
	assign num  = lca_pkg::LIN_W'(ctrl.cell_number);
	assign hit  = ctrl.mark && (num >= BASE) && (num < LIMIT);
	assign offs = num - BASE;
	assign col  = offs[COL_W-1:0];

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctrl.clear) begin
			row_q <= '0;
		end else if (ctrl.step) begin
			row_q <= gen_row;
		end else if (hit) begin
			row_q <= row_q | (GRID_SIZE'(1) << col);
		end
	end

	assign row = row_q;

endmodule

>>> hdl/life_cellular_automaton_top.sv
// Top level of the life cellular automaton: stream ports, the chain of row
// cells and the registered result word. Uses lca_pkg and lca_row_cell.
//
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tdata: cell_number, row_select; tuser: kind
//  m_*     | out | m_tvalid/m_tready | tdata: row_bits
//
// One word is taken per cycle while s_tready is high; its result appears in the output
// register on the next cycle. Clear, mark and generation step all complete at the edge
// that accepts the word: every row cell computes its whole next row with its own neighbour adders.
// Reset (arst_n low) clears the grid to all dead and empties the output register.
// s_tready drops only while a result is held and m_tready is low.
module life_cellular_automaton_top #(
	parameter int GRID_SIZE = lca_pkg::GRID_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [9:0] cell_number, [14:10] row_select, [15] zero
	input  logic [lca_pkg::S_DATA_W-1:0] s_tdata,
	// [1:0] kind
	input  logic [lca_pkg::S_USER_W-1:0] s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] row_bits
	output logic [lca_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int RB_W  = lca_pkg::RB_W;
	localparam int SEL_W = lca_pkg::SEL_W;
	localparam int IDX_W = lca_pkg::IDX_W;

	lca_pkg::kind_t        kind;
	logic [IDX_W-1:0]      cell_number;
	logic [SEL_W-1:0]      row_select;
	logic                  s_acc;
	lca_pkg::ctrl_t        ctrl;
	logic [GRID_SIZE-1:0]  row_st [GRID_SIZE];
	logic [RB_W-1:0]       row_rd [GRID_SIZE];
	logic [GRID_SIZE-1:0]  sel_hit;
	logic [RB_W-1:0]       rd_word;
	logic                  m_tvalid_q;
	logic [RB_W-1:0]       m_tdata_q;

	// unpack the input word
	assign kind        = lca_pkg::kind_t'(s_tuser[lca_pkg::KIND_W-1:0]);
	assign cell_number = s_tdata[IDX_W-1:0];
	assign row_select  = s_tdata[IDX_W+SEL_W-1:IDX_W];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	// broadcast control to the row cells
	assign ctrl.clear       = s_acc && (kind == lca_pkg::KIND_CLEAR);
	assign ctrl.mark        = s_acc && (kind == lca_pkg::KIND_MARK);
	assign ctrl.step        = s_acc && (kind == lca_pkg::KIND_STEP);
	assign ctrl.cell_number = cell_number;

	// chain of row cells, each fed by its neighbours
	for (genvar r = 0; r < GRID_SIZE; r++) begin : g_row
		logic [GRID_SIZE-1:0] up_row, dn_row;

		if (r == 0) begin : g_top
			assign up_row = '0;
		end else begin : g_up
			assign up_row = row_st[r-1];
		end

		if (r == GRID_SIZE - 1) begin : g_bot
			assign dn_row = '0;
		end else begin : g_dn
			assign dn_row = row_st[r+1];
		end

		lca_row_cell #(
			.GRID_SIZE (GRID_SIZE),
			.ROW_IDX   (r)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.up_row (up_row),
			.dn_row (dn_row),
			.row    (row_st[r])
		);

		// readback columns: only the low word of a wide row
		if (GRID_SIZE >= RB_W) begin : g_wide
			assign row_rd[r] = row_st[r][RB_W-1:0];
		end else begin : g_narrow
			assign row_rd[r] = RB_W'(row_st[r]);
		end

		// only rows reachable by row_select can be read
		if (r < (1 << SEL_W)) begin : g_sel
			assign sel_hit[r] = (row_select == SEL_W'(r));
		end else begin : g_nosel
			assign sel_hit[r] = 1'b0;
		end
	end

	// row readback select
	always_comb begin
		rd_word = '0;
		for (int r = 0; r < GRID_SIZE; r++) begin
			rd_word = rd_word | (row_rd[r] & {RB_W{sel_hit[r]}});
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tdata_q <= (kind == lca_pkg::KIND_READ) ? rd_word : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> tb/sv/life_grid_checker.sv
// Checker for the life cellular automaton: watches both stream channels, keeps its
// own copy of the grid and compares every result word with the predicted row.
// Depends on lca_pkg for field widths and the operation codes.
module life_grid_checker #(
	parameter int GRID_SIZE = lca_pkg::GRID_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [lca_pkg::S_DATA_W-1:0] s_tdata,
	input  logic [lca_pkg::S_USER_W-1:0] s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [lca_pkg::M_DATA_W-1:0] m_tdata,
	output int                           fail_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RB_W  = lca_pkg::RB_W;
	localparam int IDX_W = lca_pkg::IDX_W;
	localparam int SEL_W = lca_pkg::SEL_W;

	// board[r][c] is the cell at row r, column c
	logic [GRID_SIZE-1:0] board [GRID_SIZE];
	logic [RB_W-1:0]      expected_rows [$];

	// one generation of B3/S23, everything beyond the edges dead
	function automatic void advance_generation();
		logic [GRID_SIZE-1:0] nxt [GRID_SIZE];
		int n, nr, nc;
		for (int r = 0; r < GRID_SIZE; r++) begin
			for (int c = 0; c < GRID_SIZE; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						nr = r + dr;
						nc = c + dc;
						if ((dr != 0 || dc != 0) && nr >= 0 && nr < GRID_SIZE &&
						    nc >= 0 && nc < GRID_SIZE)
							n += int'(board[nr][nc]);
					end
				end
				nxt[r][c] = board[r][c] ? (n == 2 || n == 3) : (n == 3);
			end
		end
		board = nxt;
	endfunction

	// apply one accepted word to the grid and return the row word it should give
	function automatic logic [RB_W-1:0] apply_word(lca_pkg::kind_t k,
	                                               logic [IDX_W-1:0] idx,
	                                               logic [SEL_W-1:0] sel);
		logic [RB_W-1:0] bits;
		bits = '0;
		case (k)
			lca_pkg::KIND_CLEAR: begin
				foreach (board[r]) board[r] = '0;
			end
			lca_pkg::KIND_MARK: begin
				if (int'(idx) < GRID_SIZE * GRID_SIZE)
					board[int'(idx) / GRID_SIZE][int'(idx) % GRID_SIZE] = 1'b1;
			end
			lca_pkg::KIND_STEP: begin
				advance_generation();
			end
			lca_pkg::KIND_READ: begin
				// only the first 32 columns fit the result word
				if (int'(sel) < GRID_SIZE)
					for (int c = 0; c < RB_W && c < GRID_SIZE; c++)
						bits[c] = board[sel][c];
			end
			default: begin
				bits = '0;
			end
		endcase
		return bits;
	endfunction

	// results first (they belong to older words), then the newly accepted word
	always @(posedge clk or negedge arst_n) begin
		logic [RB_W-1:0] exp_row;
		if (!arst_n) begin
			foreach (board[r]) board[r] = '0;
			expected_rows.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual row_bits %h",
					         $time, m_tdata);
					fail_count++;
				end else begin
					exp_row = expected_rows.pop_front();
					if (m_tdata !== exp_row) begin
						$display("%0t: row_bits mismatch, expected %h actual %h",
						         $time, exp_row, m_tdata);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_rows.push_back(apply_word(lca_pkg::kind_t'(s_tuser),
				                                   s_tdata[IDX_W-1:0],
				                                   s_tdata[IDX_W+SEL_W-1:IDX_W]));
			pending = expected_rows.size();
		end
	end

endmodule

>>> tb/sv/life_cellular_automaton_top_tb.sv
// Testbench top for life_cellular_automaton_top: clock, reset, directed and random
// stimulus with idle and stall phases, and the final verdict.
// Depends on lca_pkg, the block itself and life_grid_checker.
module life_cellular_automaton_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID      = lca_pkg::GRID_SIZE_DEF;
	localparam int ITEMS     = 1800;
	localparam int LIMIT     = 400000;
	localparam int HOLD_LEN  = 90;
	localparam int IDX_W     = lca_pkg::IDX_W;
	localparam int SEL_W     = lca_pkg::SEL_W;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [lca_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic [lca_pkg::S_USER_W-1:0] s_tuser  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [lca_pkg::M_DATA_W-1:0] m_tdata;

	int fail_count;
	int pending;
	int sent         = 0;
	int send_idle    = 0;
	int recv_stall   = 0;
	bit hold_request = 1'b0;
	bit hold_taken   = 1'b0;
	int hold_left    = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	life_cellular_automaton_top #(.GRID_SIZE(GRID)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	life_grid_checker #(.GRID_SIZE(GRID)) grid_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_request && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left  = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// watchdog
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	// offer one word, with random idle cycles ahead of it, and wait for acceptance
	task automatic send_word(lca_pkg::kind_t k, logic [IDX_W-1:0] idx,
	                         logic [SEL_W-1:0] sel);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {1'b0, sel, idx};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic mark_cell(int r, int c);
		send_word(lca_pkg::KIND_MARK, IDX_W'(r * GRID + c), SEL_W'($urandom));
	endtask

	task automatic read_row(int r);
		send_word(lca_pkg::KIND_READ, IDX_W'($urandom), SEL_W'(r));
	endtask

	// an optional clear, a seeded pattern in a window, then a few generations with rows read back
	task automatic run_episode();
		int span, r0, c0, n_marks, n_steps, n_reads;
		if ($urandom_range(3) == 0)
			send_word(lca_pkg::KIND_CLEAR, IDX_W'($urandom), SEL_W'($urandom));
		case ($urandom_range(2))
			0:       span = 4;
			1:       span = 8;
			default: span = GRID;
		endcase
		r0 = $urandom_range(GRID - span);
		c0 = $urandom_range(GRID - span);
		// windows pushed against an edge now and then
		if ($urandom_range(3) == 0) r0 = ($urandom_range(1) != 0) ? 0 : GRID - span;
		if ($urandom_range(3) == 0) c0 = ($urandom_range(1) != 0) ? 0 : GRID - span;
		n_marks = $urandom_range(3, (span * span / 2 > 40) ? 40 : span * span / 2);
		for (int i = 0; i < n_marks; i++) begin
			if ($urandom_range(9) == 0)
				send_word(lca_pkg::KIND_MARK, IDX_W'($urandom), SEL_W'($urandom));
			else
				mark_cell(r0 + $urandom_range(span - 1), c0 + $urandom_range(span - 1));
		end
		n_steps = $urandom_range(1, 6);
		for (int i = 0; i < n_steps; i++) begin
			send_word(lca_pkg::KIND_STEP, IDX_W'($urandom), SEL_W'($urandom));
			n_reads = $urandom_range(1, 4);
			for (int j = 0; j < n_reads; j++) begin
				if ($urandom_range(3) == 0)
					read_row($urandom_range(GRID - 1));
				else
					read_row(r0 + $urandom_range(span - 1));
			end
		end
	endtask

	// stimulus
	initial begin
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty grid, corners, re-marking a live cell, blinker
		read_row(0);
		mark_cell(0, 0);
		mark_cell(0, 0);
		mark_cell(0, 1);
		mark_cell(1, 0);
		mark_cell(GRID - 1, GRID - 1);
		mark_cell(GRID - 1, GRID - 2);
		mark_cell(GRID - 2, GRID - 1);
		read_row(0);
		read_row(GRID - 1);
		send_word(lca_pkg::KIND_STEP, '1, '1);
		read_row(0);
		read_row(1);
		read_row(GRID - 2);
		read_row(GRID - 1);
		send_word(lca_pkg::KIND_CLEAR, '1, '1);
		read_row(0);
		mark_cell(5, 4);
		mark_cell(5, 5);
		mark_cell(5, 6);
		send_word(lca_pkg::KIND_STEP, '0, '0);
		read_row(4);
		read_row(5);
		send_word(lca_pkg::KIND_STEP, '0, '0);
		read_row(5);

		// random phases; the first one also forces a long receiver hold-off
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  hold_request = 1'b1; end
				1: begin send_idle = 58; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 58; end
				default: begin send_idle = 32; recv_stall = 32; end
			endcase
			target = sent + ITEMS / 4;
			while (sent < target) run_episode();
		end
		s_tvalid   <= 1'b0;
		send_idle  = 0;
		recv_stall = 0;

		// drain, then allow for the output register
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
hdl/lca_pkg.sv
hdl/lca_row_cell.sv
hdl/life_cellular_automaton_top.sv
tb/sv/life_grid_checker.sv
tb/sv/life_cellular_automaton_top_tb.sv
